// File: src/csvh_pkg.sv
// Package: shared types and constants for the CSV cell parser with hash.
`timescale 1ns / 1ps

package csvh_pkg;

  // Input opcodes (carried on in_tuser)
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Result kinds (carried on out_tuser)
  localparam logic [1:0] EV_CONTENT = 2'd0;
  localparam logic [1:0] EV_CELL    = 2'd1;
  localparam logic [1:0] EV_STATUS  = 2'd2;

  // Final status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_UNTERM   = 2'd3;

  // Hash modes; anything at or above HM_ZERO gives a zero hash
  localparam logic [1:0] HM_LOWER = 2'd0;
  localparam logic [1:0] HM_ZERO  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HASH_MODE    = 2'd0;
  localparam logic [1:0] REG_COLUMN_LIMIT = 2'd1;
  localparam logic [1:0] REG_ROW_LIMIT    = 2'd2;
  localparam logic [1:0] REG_CELL_LIMIT   = 2'd3;

  // Register reset values
  localparam logic [1:0]  HASH_MODE_RST    = 2'd0;
  localparam logic [10:0] COLUMN_LIMIT_RST = 11'd1024;
  localparam logic [15:0] ROW_LIMIT_RST    = 16'd65535;
  localparam logic [20:0] CELL_LIMIT_RST   = 21'd1048576;

  // Special bytes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Quote tracking state
  typedef enum logic [2:0] {
    QS_OUT  = 3'b001,
    QS_IN   = 3'b010,
    QS_PEND = 3'b100
  } qstate_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  content_byte;
    logic [31:0] cell_hash;
    logic [15:0] row_index;
    logic [9:0]  column_index;
    logic        row_done;
    logic [1:0]  status;
    logic        file_done;
  } result_t;

endpackage

// File: src/csv_cell_parser_with_hash_top.sv
// Top level: CSV cell parser with per-cell times-31 hash and final status.
// Results are queued at the accepting edge; each shows on the output once earlier results drain.
// Throughput: one request per cycle while in_tready is high; a byte gives at most one result,
// an end of file up to two; the input stalls while the four-entry queue holds more than two.
// Reset: synchronous active-low rst_n clears parse state, the queue and loads
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module csv_cell_parser_with_hash_top #(
  parameter int COL_BOUND = 1024,
  parameter int ROW_BOUND = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] opcode
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] content_byte, [39:8] cell_hash,
                                  // [55:40] row_index, [65:56] column_index,
                                  // [66] row_done, [68:67] status, [71:69] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // file_done
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  // cells_in_row and widest_row hold up to COL_BOUND; the incremented count
  // needs room for COL_BOUND+1. Likewise for rows.
  localparam int CW = $clog2(COL_BOUND + 2);
  localparam int RW = $clog2(ROW_BOUND + 2);
  localparam int CC = ((CW > 11) ? CW : 11) + 1;
  localparam int RC = ((RW > 16) ? RW : 16) + 1;
  localparam int PW = ((RW + CW > 21) ? RW + CW : 21) + 1;

  // ---------------------------------------------------------------- config
  logic [1:0]  hash_mode_r;
  logic [10:0] column_limit_r;
  logic [15:0] row_limit_r;
  logic [20:0] cell_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r    <= csvh_pkg::HASH_MODE_RST;
      column_limit_r <= csvh_pkg::COLUMN_LIMIT_RST;
      row_limit_r    <= csvh_pkg::ROW_LIMIT_RST;
      cell_limit_r   <= csvh_pkg::CELL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csvh_pkg::REG_HASH_MODE:    hash_mode_r    <= cfg_data[1:0];
        csvh_pkg::REG_COLUMN_LIMIT: column_limit_r <= cfg_data[10:0];
        csvh_pkg::REG_ROW_LIMIT:    row_limit_r    <= cfg_data[15:0];
        csvh_pkg::REG_CELL_LIMIT:   cell_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- parse state
  csvh_pkg::qstate_t qs_r, qs_nxt;
  logic          at_start_r, at_start_nxt;
  logic [31:0]   hash_r, hash_nxt;
  logic [CW-1:0] cells_r, cells_nxt;
  logic [RW-1:0] rows_r, rows_nxt;
  logic [CW-1:0] widest_r, widest_nxt;
  logic          halted_r, halted_nxt;

  // result queue
  csvh_pkg::result_t     q_mem [csvh_pkg::QDEPTH];
  logic [csvh_pkg::QAW-1:0] q_wr_r, q_rd_r;
  logic [csvh_pkg::QCW-1:0] q_cnt_r;

  logic in_fire, out_fire;
  assign in_tready = (q_cnt_r <= csvh_pkg::QCW'(csvh_pkg::QDEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // Cell-end checks against the effective limits (min of register and bound)
  logic [CW-1:0] cnt_inc;
  logic [RW-1:0] rows_inc;
  logic          col_ovf, row_ovf;
  logic [7:0]    fold_byte;
  logic [31:0]   hash_step;
  logic [31:0]   hash_out;

  assign cnt_inc  = cells_r + CW'(1);
  assign rows_inc = rows_r + RW'(1);
  assign col_ovf  = (CC'(cnt_inc) > CC'(column_limit_r)) ||
                    (CC'(cnt_inc) > CC'(COL_BOUND));
  assign row_ovf  = (RC'(rows_inc) > RC'(row_limit_r)) ||
                    (RC'(rows_inc) > RC'(ROW_BOUND));

  // lowercase fold only in mode 0; h*31 + c as shift and subtract
  assign fold_byte = (hash_mode_r == csvh_pkg::HM_LOWER &&
                      in_tdata >= csvh_pkg::CH_UP_A && in_tdata <= csvh_pkg::CH_UP_Z)
                     ? (in_tdata | csvh_pkg::CASE_BIT) : in_tdata;
  assign hash_step = (hash_r << 5) - hash_r + {24'd0, fold_byte};
  assign hash_out  = (hash_mode_r >= csvh_pkg::HM_ZERO) ? 32'd0 : hash_r;

  csvh_pkg::result_t res0, res1, res_new;
  logic [1:0]        n_push;
  logic              ce_req, ce_row, ce_ovf, eof_req, do_out, emit, start;
  logic [1:0]        st;
  logic [CW-1:0]     w_sel;
  logic [RW+CW-1:0]  prod;

  always_comb begin
    qs_nxt       = qs_r;
    at_start_nxt = at_start_r;
    hash_nxt     = hash_r;
    cells_nxt    = cells_r;
    rows_nxt     = rows_r;
    widest_nxt   = widest_r;
    halted_nxt   = halted_r;
    res0         = '0;
    res1         = '0;
    res_new      = '0;
    n_push       = 2'd0;
    ce_req       = 1'b0;
    ce_row       = 1'b0;
    ce_ovf       = 1'b0;
    eof_req      = 1'b0;
    do_out       = 1'b0;
    emit         = 1'b0;
    start        = at_start_r;
    st           = csvh_pkg::ST_OK;
    w_sel        = '0;
    prod         = '0;

    if (in_fire) begin
      if (in_tuser == csvh_pkg::OP_EOF) begin
        eof_req = 1'b1;
        if (halted_r) begin
          st = csvh_pkg::ST_TOO_MANY;
        end else if (qs_r == csvh_pkg::QS_IN) begin
          st = csvh_pkg::ST_UNTERM;
        end else if (cells_r != '0 || !at_start_r) begin
          ce_req = 1'b1;
          ce_row = 1'b1;
        end
      end else if (!halted_r) begin
        case (qs_r)
          csvh_pkg::QS_IN: begin
            if (in_tdata == csvh_pkg::CH_QUOTE) qs_nxt = csvh_pkg::QS_PEND;
            else emit = 1'b1;
          end
          csvh_pkg::QS_PEND: begin
            if (in_tdata == csvh_pkg::CH_QUOTE) begin
              qs_nxt = csvh_pkg::QS_IN;
              emit   = 1'b1;
            end else begin
              // closing quote: rest of cell is taken verbatim
              qs_nxt = csvh_pkg::QS_OUT;
              start  = 1'b0;
              do_out = 1'b1;
            end
          end
          default: do_out = 1'b1;
        endcase

        if (do_out) begin
          at_start_nxt = start;
          if (start && in_tdata == csvh_pkg::CH_QUOTE) begin
            qs_nxt       = csvh_pkg::QS_IN;
            at_start_nxt = 1'b0;
          end else if (in_tdata == csvh_pkg::CH_COMMA || in_tdata == csvh_pkg::CH_LF) begin
            ce_req = 1'b1;
            ce_row = (in_tdata == csvh_pkg::CH_LF);
          end else if (in_tdata != csvh_pkg::CH_CR) begin
            at_start_nxt = 1'b0;
            emit         = 1'b1;
          end
        end
      end
    end

    if (emit) begin
      hash_nxt             = hash_step;
      res_new.kind         = csvh_pkg::EV_CONTENT;
      res_new.content_byte = in_tdata;
      res0                 = res_new;
      n_push               = 2'd1;
    end

    if (ce_req) begin
      if (col_ovf || (ce_row && row_ovf)) begin
        ce_ovf     = 1'b1;
        halted_nxt = 1'b1;
      end else begin
        res_new              = '0;
        res_new.kind         = csvh_pkg::EV_CELL;
        res_new.cell_hash    = hash_out;
        res_new.row_index    = 16'(rows_r);
        res_new.column_index = 10'(cells_r);
        res_new.row_done     = ce_row;
        res0                 = res_new;
        n_push               = 2'd1;
        hash_nxt             = '0;
        at_start_nxt         = 1'b1;
        if (ce_row) begin
          if (cnt_inc > widest_r) widest_nxt = cnt_inc;
          rows_nxt  = rows_inc;
          cells_nxt = '0;
        end else begin
          cells_nxt = cnt_inc;
        end
      end
    end

    if (eof_req) begin
      // padded cell count: rows times widest row, at least one column
      w_sel = (widest_nxt == '0) ? CW'(1) : widest_nxt;
      prod  = rows_nxt * w_sel;
      if (st == csvh_pkg::ST_OK) begin
        if (ce_ovf) st = csvh_pkg::ST_TOO_MANY;
        else if (rows_nxt == '0) st = csvh_pkg::ST_EMPTY;
        else if (PW'(prod) > PW'(cell_limit_r)) st = csvh_pkg::ST_TOO_MANY;
      end
      res_new           = '0;
      res_new.kind      = csvh_pkg::EV_STATUS;
      res_new.status    = st;
      res_new.file_done = 1'b1;
      if (n_push == 2'd0) begin
        res0   = res_new;
        n_push = 2'd1;
      end else begin
        res1   = res_new;
        n_push = 2'd2;
      end
      // ready for the next file
      qs_nxt       = csvh_pkg::QS_OUT;
      at_start_nxt = 1'b1;
      hash_nxt     = '0;
      cells_nxt    = '0;
      rows_nxt     = '0;
      widest_nxt   = '0;
      halted_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_r       <= csvh_pkg::QS_OUT;
      at_start_r <= 1'b1;
      hash_r     <= '0;
      cells_r    <= '0;
      rows_r     <= '0;
      widest_r   <= '0;
      halted_r   <= 1'b0;
    end else begin
      qs_r       <= qs_nxt;
      at_start_r <= at_start_nxt;
      hash_r     <= hash_nxt;
      cells_r    <= cells_nxt;
      rows_r     <= rows_nxt;
      widest_r   <= widest_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // ---------------------------------------------------------------- result queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_mem[q_wr_r] <= res0;
    if (n_push == 2'd2) q_mem[q_wr_r + csvh_pkg::QAW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + csvh_pkg::QAW'(n_push);
      if (out_fire) q_rd_r <= q_rd_r + csvh_pkg::QAW'(1);
      q_cnt_r <= q_cnt_r + csvh_pkg::QCW'(n_push) - csvh_pkg::QCW'(out_fire);
    end
  end

  csvh_pkg::result_t head;
  assign head       = q_mem[q_rd_r];
  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.file_done;
  assign out_tdata  = {3'd0, head.status, head.row_done, head.column_index,
                       head.row_index, head.cell_hash, head.content_byte};

endmodule
